// ----- rtl/hce_pkg.sv -----
`default_nettype none
package hce_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int HASH_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int BCFG_W      = 5;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int STATUS_W    = 2;

  localparam int TBL_AW      = $clog2(TABLE_DEPTH);

  // remainder is reduced a few hash bits per cycle
  localparam int DIGIT_W     = 4;
  localparam int DIV_STEPS   = HASH_W / DIGIT_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BCFG_W-1:0] BUCKET_RESET = BCFG_W'(16);

  localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 2'd2;

  typedef struct packed {
    logic [HASH_W-1:0]      hash;
    logic [VALUE_WIDTH-1:0] value;
  } hce_entry_t;

endpackage
`default_nettype wire

// ----- rtl/hce_ram.sv -----
`default_nettype none
module hce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hce_front.sv -----
`default_nettype none
module hce_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [hce_pkg::BYTE_W-1:0]    key_byte,
  input  wire logic                          byte_present,
  input  wire logic                          key_end,
  input  wire logic [hce_pkg::VALUE_WIDTH-1:0] stored_value,
  input  wire logic                          q_full,
  output logic                               q_push,
  output hce_pkg::hce_entry_t                q_data
);
  import hce_pkg::*;

  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] hash_next;
  logic [HASH_W-1:0] hash_upd;
  logic              xfer;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;

  // with byte_present, rotate left by one, then fold in the byte; else the hash is kept
  assign hash_upd = byte_present ?
                    ({hash[HASH_W-2:0], hash[HASH_W-1]} ^ HASH_W'(key_byte)) : hash;

  always_comb begin
    hash_next = hash;
    if (xfer) begin
      hash_next = key_end ? '0 : hash_upd;
    end
  end

  assign q_push = xfer && key_end;
  assign q_data = '{hash: hash_upd, value: stored_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else begin
      hash <= hash_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hce_queue.sv -----
`default_nettype none
module hce_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hce_pkg::hce_entry_t wdata,
  output hce_pkg::hce_entry_t      rdata,
  input  wire logic                push,
  input  wire logic                pop,
  output logic                     full,
  output logic                     empty
);
  import hce_pkg::*;

  hce_entry_t        slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + QCNT_W'(push && !full) - QCNT_W'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hce_back.sv -----
`default_nettype none
module hce_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [hce_pkg::BCFG_W-1:0]     bucket_count,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  input  wire hce_pkg::hce_entry_t            q_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [hce_pkg::STATUS_W-1:0]   status,
  output logic      [hce_pkg::IDX_W-1:0]      bucket_index,
  output logic      [hce_pkg::CNT_W-1:0]      entry_count
);
  import hce_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [HASH_W-1:0]      shreg;
  logic [VALUE_WIDTH-1:0] value;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       rem_next;
  logic [STEP_W-1:0]      step;
  logic [TABLE_DEPTH-1:0] mark;
  logic [CNT_W-1:0]       filled;
  logic [CNT_W-1:0]       n_eff;
  logic [TBL_AW-1:0]      slot_idx;
  logic                   is_full;
  logic                   is_occ;
  logic                   commit;
  logic                   do_store;

  always_comb begin
    if (bucket_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(bucket_count) > 32'(TABLE_DEPTH)) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(bucket_count);
    end
  end

  // restoring remainder, a digit of hash bits per cycle
  always_comb begin
    logic [CNT_W:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < DIGIT_W; i++) begin
      r = {r[CNT_W-1:0], shreg[HASH_W-1-i]};
      if (r >= {1'b0, n_eff}) begin
        r = r - {1'b0, n_eff};
      end
    end
    rem_next = r[CNT_W-1:0];
  end

  assign slot_idx = rem[TBL_AW-1:0];
  assign is_full  = (filled >= n_eff);
  assign is_occ   = mark[slot_idx];
  assign commit   = (state == S_COMMIT) && (!out_valid || out_ready);
  assign do_store = commit && !is_full && !is_occ;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mark      <= '0;
      filled    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end
      if (do_store) begin
        mark[slot_idx] <= 1'b1;
        filled         <= filled + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shreg <= q_data.hash;
      value <= q_data.value;
      rem   <= '0;
      step  <= '0;
    end else if (state == S_DIV) begin
      shreg <= shreg << DIGIT_W;
      rem   <= rem_next;
      step  <= step + 1'b1;
    end
    if (commit) begin
      bucket_index <= IDX_W'(rem);
      if (is_full) begin
        status      <= ST_FULL;
        entry_count <= filled;
      end else if (is_occ) begin
        status      <= ST_OCCUPIED;
        entry_count <= filled;
      end else begin
        status      <= ST_STORED;
        entry_count <= filled + 1'b1;
      end
    end
  end

  hce_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_store),
    .waddr (slot_idx),
    .wdata (value),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

endmodule
`default_nettype wire

// ----- rtl/hash_table_insert_engine.sv -----
// key bytes are taken one per cycle while the queue is not full; the back end
//   handles one key at a time: pop, 8-step remainder (4 hash bits a step), commit
// a 2-entry queue lets the front keep hashing while a key is being inserted
// reset: synchronous; clears hash, occupancy marks, entry count, queue and
//   output; bucket_count returns to 16; stored values are not cleared
`default_nettype none
module hash_table_insert_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [hce_pkg::BCFG_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [hce_pkg::BYTE_W-1:0]       key_byte,
  input  wire logic                             byte_present,
  input  wire logic                             key_end,
  input  wire logic [hce_pkg::VALUE_WIDTH-1:0]  stored_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [hce_pkg::STATUS_W-1:0]     status,
  output logic      [hce_pkg::IDX_W-1:0]        bucket_index,
  output logic      [hce_pkg::CNT_W-1:0]        entry_count
);
  import hce_pkg::*;

  logic [BCFG_W-1:0] bucket_count;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  hce_entry_t        q_wdata;
  hce_entry_t        q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  hce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .key_byte     (key_byte),
    .byte_present (byte_present),
    .key_end      (key_end),
    .stored_value (stored_value),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  hce_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wdata (q_wdata),
    .rdata (q_rdata),
    .push  (q_push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty)
  );

  hce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .bucket_index (bucket_index),
    .entry_count  (entry_count)
  );

endmodule
`default_nettype wire

// ----- rtl/hce_checker.sv -----
`default_nettype none
module hce_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [hce_pkg::STATUS_W-1:0] status,
  input wire logic [hce_pkg::IDX_W-1:0]    bucket_index,
  input wire logic [hce_pkg::CNT_W-1:0]    entry_count
);
  import hce_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
    $stable(bucket_index) && $stable(entry_count))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stored_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_STORED |-> entry_count != '0)
    else $error("stored with zero entry count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count != '0)
    else $error("full reported on empty table");

endmodule

bind hash_table_insert_engine hce_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .bucket_index (bucket_index),
  .entry_count  (entry_count)
);
`default_nettype wire
